// ===== rtl/backtick_quoted_word_splitter_core_assert.svh =====
// Assertion macros shared by the splitter modules.
// Each expects signals named clk and rst_n in the module that uses it.
`ifndef BACKTICK_QUOTED_WORD_SPLITTER_CORE_ASSERT_SVH
`define BACKTICK_QUOTED_WORD_SPLITTER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Check that a condition holds at every clock edge out of reset.
`define BQWS_ASSERT_HOLDS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error(msg);

// Check that one condition implies another in the same cycle.
`define BQWS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that one condition implies another in the next cycle.
`define BQWS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define BQWS_ASSERT_HOLDS(label, expr, msg)
`define BQWS_ASSERT_IMPL(label, ante, cons, msg)
`define BQWS_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ===== rtl/bqws_pkg.sv =====
package bqws_pkg;

  // Largest number of results a single input character can cause.
  localparam int RES_MAX = 3;
  localparam int RES_CNT_W = $clog2(RES_MAX + 1);

  // Character codes with a special meaning.
  localparam logic [7:0] CH_TICK   = 8'h60;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  typedef enum logic [1:0] {
    MODE_UNQ = 2'd0,
    MODE_QUO = 2'd1,
    MODE_ERR = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    K_CHAR = 2'd0,
    K_END  = 2'd1,
    K_ERR  = 2'd2,
    K_DONE = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    E_NONE   = 3'd0,
    E_TICK   = 3'd1,
    E_RSVD   = 3'd2,
    E_HASH   = 3'd3,
    E_UNTERM = 3'd4
  } err_t;

  // One result item.
  typedef struct packed {
    kind_t      kind;
    logic [7:0] ch;
    err_t       err;
  } ent_t;

  // All results of one character, handed to the output buffer at once.
  typedef struct packed {
    logic                 vld;
    logic [RES_CNT_W-1:0] cnt;
    ent_t [RES_MAX-1:0]   ent;
  } res_list_t;

  // Build a result with the unused fields cleared.
  function automatic ent_t mk_ent(kind_t kind, logic [7:0] ch, err_t err);
    ent_t e;
    e.kind = kind;
    e.ch   = (kind == K_CHAR) ? ch : 8'd0;
    e.err  = (kind == K_ERR) ? err : E_NONE;
    return e;
  endfunction

  function automatic logic is_reserved(logic [7:0] c);
    return c inside {CH_DOLLAR, 8'h2A, 8'h7E, 8'h3C, 8'h3E, 8'h7C, 8'h3B,
                     8'h28, 8'h29, 8'h5B, 8'h5D, 8'h7B, 8'h7D, 8'h27, 8'h22,
                     CH_BSLASH};
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return c inside {CH_SPACE, CH_TAB, CH_LF, CH_CR};
  endfunction

endpackage

// ===== rtl/backtick_quoted_word_splitter_core.sv =====
// Backtick-quoted word splitter. One character enters per input transfer, and a
// transfer with in_tlast high marks the end of the content; its character is
// ignored. Each character yields zero to three results (word character, word
// end, error, content done), delivered one per output transfer, with out_tlast
// on the last result of that character. Characters that yield zero or one result
// stream at one per cycle while the output side is ready; one that yields
// several results holds the output port until all of them have transferred. A
// character's results pass through the input register and then the result
// buffer, which offers them on the output port. The pace is set by the single
// output port of the result buffer; the input register accepts the next
// character while results of the previous one are still waiting. After an
// error, characters produce nothing until the end marker, which then reports
// only completion and returns the parser to its reset state.
module backtick_quoted_word_splitter_core
  import bqws_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // char_in [7:0]
  input  logic        in_tlast,   // is_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // out_char [7:0], error_code [10:8], zero fill
  output logic [1:0]  out_tuser,  // kind [1:0]
  output logic        out_tlast
);

  res_list_t res_list;
  logic      buf_ready;

  // Parser: input register, state and the per-character result list.
  bqws_step u_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .buf_ready (buf_ready),
    .res_list  (res_list)
  );

  // Result buffer: serializes the list onto the output channel.
  bqws_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_list   (res_list),
    .buf_ready  (buf_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== rtl/bqws_step.sv =====
`include "backtick_quoted_word_splitter_core_assert.svh"

module bqws_step
  import bqws_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic       in_tlast,
  input  logic       buf_ready,
  output res_list_t  res_list
);

  logic       in_valid_r, in_valid_nxt;
  logic [7:0] char_r;
  logic       end_r;
  logic       fire;

  mode_t      mode_r, mode_nxt;
  logic       word_open_r, word_open_nxt;
  logic       tick_pending_r, tick_pending_nxt;
  logic       space_pending_r, space_pending_nxt;
  logic [1:0] tick_run_r, tick_run_nxt;

  ent_t [RES_MAX-1:0]   res_v;
  logic [RES_CNT_W-1:0] n_v;
  logic                 do_unq;

  // The input register takes a new transfer when it is empty or its item moves on.
  assign fire         = in_valid_r && buf_ready;
  assign in_tready    = !in_valid_r || fire;
  assign in_valid_nxt = (in_tvalid && in_tready) || (in_valid_r && !fire);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
    if (in_tvalid && in_tready) begin
      char_r <= in_tdata;
      end_r  <= in_tlast;
    end
  end

  // Parser state advances once per character handed to the buffer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r          <= MODE_UNQ;
      word_open_r     <= 1'b0;
      tick_pending_r  <= 1'b0;
      space_pending_r <= 1'b0;
      tick_run_r      <= 2'd0;
    end else if (fire) begin
      mode_r          <= mode_nxt;
      word_open_r     <= word_open_nxt;
      tick_pending_r  <= tick_pending_nxt;
      space_pending_r <= space_pending_nxt;
      tick_run_r      <= tick_run_nxt;
    end
  end

  // Results and next state for the character in the input register.
  always_comb begin
    mode_nxt          = mode_r;
    word_open_nxt     = word_open_r;
    tick_pending_nxt  = tick_pending_r;
    space_pending_nxt = space_pending_r;
    tick_run_nxt      = tick_run_r;
    res_v             = '0;
    n_v               = '0;
    do_unq            = 1'b0;

    if (end_r) begin
      // End of content: flush whatever is open, then report completion.
      case (mode_r)
        MODE_UNQ: begin
          if (tick_pending_r) begin
            res_v[n_v] = mk_ent(K_ERR, 8'd0, E_TICK);
            n_v = n_v + 1'b1;
          end else if (word_open_r) begin
            res_v[n_v] = mk_ent(K_END, 8'd0, E_NONE);
            n_v = n_v + 1'b1;
          end
        end
        MODE_QUO: begin
          if (tick_run_r == 2'd2) begin
            res_v[n_v] = mk_ent(K_END, 8'd0, E_NONE);
          end else begin
            res_v[n_v] = mk_ent(K_ERR, 8'd0, E_UNTERM);
          end
          n_v = n_v + 1'b1;
        end
        default: begin
        end
      endcase
      res_v[n_v] = mk_ent(K_DONE, 8'd0, E_NONE);
      n_v = n_v + 1'b1;
      mode_nxt          = MODE_UNQ;
      word_open_nxt     = 1'b0;
      tick_pending_nxt  = 1'b0;
      space_pending_nxt = 1'b0;
      tick_run_nxt      = 2'd0;
    end else begin
      case (mode_r)
        MODE_UNQ: begin
          if (tick_pending_r) begin
            tick_pending_nxt = 1'b0;
            if (char_r == CH_TICK) begin
              // Doubled backtick: any open word ends, a quoted word begins.
              if (word_open_r) begin
                res_v[n_v] = mk_ent(K_END, 8'd0, E_NONE);
                n_v = n_v + 1'b1;
              end
              word_open_nxt     = 1'b0;
              mode_nxt          = MODE_QUO;
              tick_run_nxt      = 2'd0;
              space_pending_nxt = 1'b0;
            end else begin
              res_v[n_v] = mk_ent(K_ERR, 8'd0, E_TICK);
              n_v = n_v + 1'b1;
              mode_nxt          = MODE_ERR;
              word_open_nxt     = 1'b0;
              space_pending_nxt = 1'b0;
              tick_run_nxt      = 2'd0;
            end
          end else begin
            do_unq = 1'b1;
          end
        end
        MODE_QUO: begin
          if (char_r == CH_TICK) begin
            case (tick_run_r)
              2'd0, 2'd1: begin
                tick_run_nxt = tick_run_r + 2'd1;
              end
              2'd2: begin
                // Third backtick in a row: a verbatim run starts.
                if (space_pending_r) begin
                  res_v[n_v] = mk_ent(K_CHAR, CH_SPACE, E_NONE);
                  n_v = n_v + 1'b1;
                end
                space_pending_nxt = 1'b0;
                res_v[n_v] = mk_ent(K_CHAR, CH_TICK, E_NONE);
                n_v = n_v + 1'b1;
                res_v[n_v] = mk_ent(K_CHAR, CH_TICK, E_NONE);
                n_v = n_v + 1'b1;
                tick_run_nxt = 2'd3;
              end
              default: begin
                res_v[n_v] = mk_ent(K_CHAR, CH_TICK, E_NONE);
                n_v = n_v + 1'b1;
              end
            endcase
          end else if (tick_run_r == 2'd2) begin
            // Exactly two backticks closed the quote; the pending space drops.
            res_v[n_v] = mk_ent(K_END, 8'd0, E_NONE);
            n_v = n_v + 1'b1;
            mode_nxt          = MODE_UNQ;
            tick_run_nxt      = 2'd0;
            space_pending_nxt = 1'b0;
            word_open_nxt     = 1'b0;
            do_unq            = 1'b1;
          end else begin
            // A single backtick inside quotes is kept as text.
            if (tick_run_r == 2'd1) begin
              if (space_pending_r) begin
                res_v[n_v] = mk_ent(K_CHAR, CH_SPACE, E_NONE);
                n_v = n_v + 1'b1;
              end
              res_v[n_v] = mk_ent(K_CHAR, CH_TICK, E_NONE);
              n_v = n_v + 1'b1;
            end else if (space_pending_r) begin
              res_v[n_v] = mk_ent(K_CHAR, CH_SPACE, E_NONE);
              n_v = n_v + 1'b1;
            end
            tick_run_nxt = 2'd0;
            if (char_r == CH_SPACE) begin
              space_pending_nxt = 1'b1;
            end else begin
              space_pending_nxt = 1'b0;
              res_v[n_v] = mk_ent(K_CHAR, char_r, E_NONE);
              n_v = n_v + 1'b1;
            end
          end
        end
        default: begin
          // Error mode swallows characters until the end marker.
        end
      endcase

      // Plain unquoted character, also after a quote has just closed.
      if (do_unq) begin
        if (is_space(char_r)) begin
          if (word_open_nxt) begin
            res_v[n_v] = mk_ent(K_END, 8'd0, E_NONE);
            n_v = n_v + 1'b1;
          end
          word_open_nxt = 1'b0;
        end else if (char_r == CH_TICK) begin
          tick_pending_nxt = 1'b1;
        end else if (is_reserved(char_r) || (char_r == CH_HASH && !word_open_nxt)) begin
          res_v[n_v] = mk_ent(K_ERR, 8'd0, is_reserved(char_r) ? E_RSVD : E_HASH);
          n_v = n_v + 1'b1;
          mode_nxt          = MODE_ERR;
          word_open_nxt     = 1'b0;
          tick_pending_nxt  = 1'b0;
          space_pending_nxt = 1'b0;
          tick_run_nxt      = 2'd0;
        end else begin
          res_v[n_v] = mk_ent(K_CHAR, char_r, E_NONE);
          n_v = n_v + 1'b1;
          word_open_nxt = 1'b1;
        end
      end
    end
  end

  assign res_list.vld = fire;
  assign res_list.cnt = n_v;
  assign res_list.ent = res_v;

  // The flags of one mode are always clear in the others.
  `BQWS_ASSERT_IMPL(a_tick_pending_unq, tick_pending_r, mode_r == MODE_UNQ,
    "Unquoted backtick pending outside unquoted mode")
  `BQWS_ASSERT_IMPL(a_word_open_unq, word_open_r, mode_r == MODE_UNQ,
    "Unquoted word open outside unquoted mode")
  `BQWS_ASSERT_IMPL(a_quote_flags, space_pending_r || (tick_run_r != 2'd0),
    mode_r == MODE_QUO, "Quote flags set outside quoted mode")

endmodule

// ===== rtl/bqws_out_buf.sv =====
`include "backtick_quoted_word_splitter_core_assert.svh"

module bqws_out_buf
  import bqws_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  res_list_t   res_list,
  output logic        buf_ready,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // out_char [7:0], error_code [10:8], zero fill
  output logic [1:0]  out_tuser,  // kind [1:0]
  output logic        out_tlast
);

  logic [RES_CNT_W-1:0] cnt_r, cnt_nxt;
  ent_t [RES_MAX-1:0]   ent_r, ent_nxt;
  logic                 pop;
  logic                 load;

  assign pop       = (cnt_r != '0) && out_tready;
  assign buf_ready = (cnt_r == '0) || ((cnt_r == RES_CNT_W'(1)) && out_tready);
  assign load      = res_list.vld;

  // A new list replaces the buffer once it is empty or drains this cycle.
  always_comb begin
    cnt_nxt = cnt_r;
    ent_nxt = ent_r;
    if (load) begin
      cnt_nxt = res_list.cnt;
      ent_nxt = res_list.ent;
    end else if (pop) begin
      cnt_nxt = cnt_r - 1'b1;
      for (int i = 0; i < RES_MAX - 1; i++) begin
        ent_nxt[i] = ent_r[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    ent_r <= ent_nxt;
  end

  // The head entry drives the result channel.
  assign out_tvalid = (cnt_r != '0);
  assign out_tdata  = {5'd0, ent_r[0].err, ent_r[0].ch};
  assign out_tuser  = ent_r[0].kind;
  assign out_tlast  = (cnt_r == RES_CNT_W'(1));

  `BQWS_ASSERT_IMPL(a_load_when_ready, load, buf_ready,
    "Result list loaded while the buffer still holds results")
  `BQWS_ASSERT_HOLDS(a_cnt_range, cnt_r <= RES_CNT_W'(RES_MAX),
    "Result count beyond buffer depth")
  `BQWS_ASSERT_NEXT(a_drain_step, pop && !load, cnt_r == $past(cnt_r) - 1'b1,
    "Buffer did not drain by one after a transfer")

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import bqws_pkg::*;

  localparam int ITEM_GOAL = 460;

  // One expected result, in the order the block delivers them.
  typedef struct packed {
    kind_t      kind;
    logic [7:0] ch;
    err_t       err;
    logic       last;
  } token_t;

  localparam token_t NIL_TOK = '0;

  // One directed stimulus row; a negative count means the predictor decides.
  typedef struct {
    logic [7:0] ch;
    logic       eoc;
    int         nfix;
    token_t     t0;
    token_t     t1;
  } row_t;

  // Character pools for the random text.
  typedef enum {P_WORD, P_BLANK, P_QUOTED, P_NOISE} pool_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  // Typed expectation that travels with the character being driven.
  int          row_nfix = -1;
  token_t      row_tok0 = '0;
  token_t      row_tok1 = '0;

  row_t        dir_rows[$];
  token_t      due_tokens[$];
  token_t      step_tok[$];
  int          live_items = 0;
  int          bad_cnt = 0;
  int          hold_cnt = 0;
  logic        calm = 1'b0;

  // Predictor state of the splitter.
  mode_t       sp_mode;
  logic        sp_word;
  logic        sp_tick;
  logic        sp_space;
  logic [1:0]  sp_run;

  backtick_quoted_word_splitter_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #1 clk = ~clk;

  // Run length guard.
  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic token_t mk_tok(kind_t k, logic [7:0] c, err_t e, logic l);
    token_t t;
    t.kind = k;
    t.ch   = (k == K_CHAR) ? c : 8'h00;
    t.err  = (k == K_ERR) ? e : E_NONE;
    t.last = l;
    return t;
  endfunction

  function automatic logic blank_ch(logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
  endfunction

  function automatic logic rsvd_ch(logic [7:0] c);
    case (c)
      CH_DOLLAR, "*", "~", "<", ">", "|", ";", "(", ")", "[", "]", "{", "}",
      "'", "\"", CH_BSLASH: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // Idle length: mostly none or short, now and then long, none in calm phases.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] pick_char(pool_t p);
    int r;
    logic [7:0] c;
    r = $urandom_range(0, 99);
    c = 8'($urandom_range(0, 255));
    case (p)
      P_BLANK: begin
        case (r % 4)
          0: c = CH_SPACE;
          1: c = CH_TAB;
          2: c = CH_LF;
          default: c = CH_CR;
        endcase
      end
      P_WORD: begin
        if (r < 70) begin
          c = 8'("a" + $urandom_range(0, 25));
        end else begin
          while (blank_ch(c) || rsvd_ch(c) || c == CH_TICK) c = 8'($urandom_range(0, 255));
        end
      end
      P_QUOTED: begin
        if (r < 55) c = 8'("a" + $urandom_range(0, 25));
        else if (r < 80) c = CH_SPACE;
        else if (r < 90) c = CH_TICK;
      end
      default: begin
        // Noise: any byte, a reserved character, a hash or a lone backtick.
        case (r % 4)
          0: ;
          1: while (!rsvd_ch(c)) c = 8'($urandom_range(0, 255));
          2: c = CH_HASH;
          default: c = CH_TICK;
        endcase
      end
    endcase
    return c;
  endfunction

  task automatic flag_token(string what, int got, int want_v);
    $display("%0t: %s mismatch: got 0x%0h, expected 0x%0h", $time, what, got, want_v);
    bad_cnt++;
  endtask

  task automatic put_tok(kind_t k, logic [7:0] c, err_t e);
    step_tok.insert(step_tok.size(), mk_tok(k, c, e, 1'b0));
  endtask

  task automatic clear_split();
    sp_mode  = MODE_UNQ;
    sp_word  = 1'b0;
    sp_tick  = 1'b0;
    sp_space = 1'b0;
    sp_run   = 2'd0;
  endtask

  task automatic trip(err_t e);
    put_tok(K_ERR, 8'h00, e);
    clear_split();
    sp_mode = MODE_ERR;
  endtask

  // A quoted space is only kept once something other than the closing pair follows.
  task automatic flush_space();
    if (sp_space) put_tok(K_CHAR, CH_SPACE, E_NONE);
    sp_space = 1'b0;
  endtask

  task automatic take_unquoted(logic [7:0] c);
    if (blank_ch(c)) begin
      if (sp_word) put_tok(K_END, 8'h00, E_NONE);
      sp_word = 1'b0;
    end else if (c == CH_TICK) begin
      sp_tick = 1'b1;
    end else if (rsvd_ch(c)) begin
      trip(E_RSVD);
    end else if (c == CH_HASH && !sp_word) begin
      trip(E_HASH);
    end else begin
      put_tok(K_CHAR, c, E_NONE);
      sp_word = 1'b1;
    end
  endtask

  // Works out the results of one input transfer into step_tok.
  task automatic split_char(logic [7:0] c, logic eoc);
    step_tok.delete();
    if (eoc) begin
      if (sp_mode == MODE_UNQ) begin
        if (sp_tick) put_tok(K_ERR, 8'h00, E_TICK);
        else if (sp_word) put_tok(K_END, 8'h00, E_NONE);
      end else if (sp_mode == MODE_QUO) begin
        if (sp_run == 2'd2) put_tok(K_END, 8'h00, E_NONE);
        else put_tok(K_ERR, 8'h00, E_UNTERM);
      end
      put_tok(K_DONE, 8'h00, E_NONE);
      clear_split();
    end else if (sp_mode == MODE_UNQ) begin
      if (sp_tick) begin
        // Second backtick opens a quote; anything else makes the first one lone.
        sp_tick = 1'b0;
        if (c == CH_TICK) begin
          if (sp_word) put_tok(K_END, 8'h00, E_NONE);
          sp_word  = 1'b0;
          sp_mode  = MODE_QUO;
          sp_run   = 2'd0;
          sp_space = 1'b0;
        end else begin
          trip(E_TICK);
        end
      end else begin
        take_unquoted(c);
      end
    end else if (sp_mode == MODE_QUO) begin
      if (c == CH_TICK) begin
        if (sp_run < 2'd2) begin
          sp_run = sp_run + 2'd1;
        end else if (sp_run == 2'd2) begin
          flush_space();
          put_tok(K_CHAR, CH_TICK, E_NONE);
          put_tok(K_CHAR, CH_TICK, E_NONE);
          sp_run = 2'd3;
        end else begin
          put_tok(K_CHAR, CH_TICK, E_NONE);
        end
      end else if (sp_run == 2'd2) begin
        // Exactly two backticks closed the quote.
        put_tok(K_END, 8'h00, E_NONE);
        sp_mode  = MODE_UNQ;
        sp_run   = 2'd0;
        sp_space = 1'b0;
        sp_word  = 1'b0;
        take_unquoted(c);
      end else begin
        if (sp_run == 2'd1) begin
          flush_space();
          put_tok(K_CHAR, CH_TICK, E_NONE);
        end
        sp_run = 2'd0;
        flush_space();
        if (c == CH_SPACE) sp_space = 1'b1;
        else put_tok(K_CHAR, c, E_NONE);
      end
    end
    if (step_tok.size() > 0) step_tok[step_tok.size() - 1].last = 1'b1;
  endtask

  task automatic add_row(logic [7:0] c, logic eoc, int nfix, token_t t0, token_t t1);
    dir_rows.insert(dir_rows.size(), '{c, eoc, nfix, t0, t1});
  endtask

  // Drives one character and waits for its transfer.
  task automatic push_char(logic [7:0] c, logic eoc, int nfix, token_t t0, token_t t1);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= eoc;
    row_nfix  <= nfix;
    row_tok0  <= t0;
    row_tok1  <= t1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic send_byte(logic [7:0] c);
    push_char(c, 1'b0, -1, NIL_TOK, NIL_TOK);
  endtask

  // One random line of text: words, blanks, quoted words and some noise.
  task automatic send_line();
    int ntok;
    int len;
    int r;
    calm = ($urandom_range(0, 4) == 0);
    ntok = $urandom_range(1, 6);
    repeat (ntok) begin
      r = $urandom_range(0, 99);
      if (r < 35) begin
        len = $urandom_range(1, 6);
        repeat (len) send_byte(pick_char(P_WORD));
      end else if (r < 55) begin
        len = $urandom_range(1, 3);
        repeat (len) send_byte(pick_char(P_BLANK));
      end else if (r < 87) begin
        send_byte(CH_TICK);
        send_byte(CH_TICK);
        len = $urandom_range(0, 6);
        repeat (len) send_byte(pick_char(P_QUOTED));
        // Now and then the closing pair is left short.
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : 2;
        repeat (len) send_byte(CH_TICK);
      end else begin
        send_byte(pick_char(P_NOISE));
      end
    end
    push_char(8'($urandom_range(0, 255)), 1'b1, -1, NIL_TOK, NIL_TOK);
  endtask

  // Result side stalls.
  always @(posedge clk) begin
    if (hold_cnt > 0) begin
      out_tready <= 1'b0;
      hold_cnt   <= hold_cnt - 1;
    end else begin
      out_tready <= 1'b1;
      hold_cnt   <= idle_len();
    end
  end

  // Predict the results of each accepted character.
  always @(posedge clk) begin : in_mon
    if (rst_n && in_tvalid && in_tready) begin
      split_char(in_tdata, in_tlast);
      if (row_nfix >= 0) begin
        step_tok.delete();
        if (row_nfix > 0) step_tok.insert(step_tok.size(), row_tok0);
        if (row_nfix > 1) step_tok.insert(step_tok.size(), row_tok1);
      end
      foreach (step_tok[i]) due_tokens.insert(due_tokens.size(), step_tok[i]);
      live_items++;
    end
  end

  // Compare each result transfer with the oldest expectation.
  always @(posedge clk) begin : out_mon
    token_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (due_tokens.size() == 0) begin
        flag_token("unexpected result, kind", int'(out_tuser), 0);
      end else begin
        want = due_tokens[0];
        due_tokens.delete(0);
        if (out_tuser != want.kind) flag_token("kind", int'(out_tuser), int'(want.kind));
        if (out_tdata[7:0] != want.ch)
          flag_token("out_char", int'(out_tdata[7:0]), int'(want.ch));
        if (out_tdata[10:8] != want.err)
          flag_token("error_code", int'(out_tdata[10:8]), int'(want.err));
        if (out_tdata[15:11] != 5'd0) flag_token("tdata fill", int'(out_tdata[15:11]), 0);
        if (out_tlast != want.last) flag_token("last", int'(out_tlast), int'(want.last));
      end
    end
  end

  initial begin
    clear_split();

    // Directed text: byte extremes, a word right before a quote, a lone
    // backtick in quotes, a held space before a backtick run, verbatim
    // runs, an unterminated quote, error mode, leading hash, an empty quoted
    // word and a backtick left pending at the end marker.
    add_row(8'h00, 1'b0, 1, mk_tok(K_CHAR, 8'h00, E_NONE, 1'b1), NIL_TOK);
    add_row(8'hFF, 1'b0, 1, mk_tok(K_CHAR, 8'hFF, E_NONE, 1'b1), NIL_TOK);
    add_row(CH_TICK, 1'b0, 0, NIL_TOK, NIL_TOK);
    add_row(CH_TICK, 1'b0, 1, mk_tok(K_END, 8'h00, E_NONE, 1'b1), NIL_TOK);
    add_row("x", 1'b0, -1, NIL_TOK, NIL_TOK);
    add_row(CH_TICK, 1'b0, -1, NIL_TOK, NIL_TOK);
    add_row("y", 1'b0, -1, NIL_TOK, NIL_TOK);
    add_row(CH_SPACE, 1'b0, -1, NIL_TOK, NIL_TOK);
    repeat (4) add_row(CH_TICK, 1'b0, -1, NIL_TOK, NIL_TOK);
    add_row(CH_DOLLAR, 1'b0, -1, NIL_TOK, NIL_TOK);
    add_row(8'hFF, 1'b1, 2, mk_tok(K_ERR, 8'h00, E_UNTERM, 1'b0),
            mk_tok(K_DONE, 8'h00, E_NONE, 1'b1));
    add_row(CH_DOLLAR, 1'b0, 1, mk_tok(K_ERR, 8'h00, E_RSVD, 1'b1), NIL_TOK);
    add_row("q", 1'b0, 0, NIL_TOK, NIL_TOK);
    add_row(8'h00, 1'b1, 1, mk_tok(K_DONE, 8'h00, E_NONE, 1'b1), NIL_TOK);
    add_row(CH_HASH, 1'b0, 1, mk_tok(K_ERR, 8'h00, E_HASH, 1'b1), NIL_TOK);
    add_row(8'h00, 1'b1, 1, mk_tok(K_DONE, 8'h00, E_NONE, 1'b1), NIL_TOK);
    repeat (4) add_row(CH_TICK, 1'b0, -1, NIL_TOK, NIL_TOK);
    add_row("w", 1'b0, -1, NIL_TOK, NIL_TOK);
    add_row(8'h00, 1'b1, -1, NIL_TOK, NIL_TOK);
    add_row(CH_TICK, 1'b0, 0, NIL_TOK, NIL_TOK);
    add_row(8'hFF, 1'b1, 2, mk_tok(K_ERR, 8'h00, E_TICK, 1'b0),
            mk_tok(K_DONE, 8'h00, E_NONE, 1'b1));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      push_char(dir_rows[i].ch, dir_rows[i].eoc, dir_rows[i].nfix,
                dir_rows[i].t0, dir_rows[i].t1);
    end

    // Random lines until enough characters have been sent.
    while (live_items < ITEM_GOAL) send_line();
    in_tvalid <= 1'b0;
    calm = 1'b0;

    // Drain the result side, then give stray results a chance to show up.
    while (due_tokens.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    if (bad_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
